// File: hw/rtl/lens_distortion_point_map_defines.svh
// Assertion macros shared by the lens distortion checker
`ifndef LENS_DISTORTION_POINT_MAP_DEFINES_SVH
`define LENS_DISTORTION_POINT_MAP_DEFINES_SVH

// same-cycle property, off during reset
`define LDPM_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ldpm check failed");

// next-cycle property, off during reset
`define LDPM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ldpm check failed");

// next-cycle property, active during reset
`define LDPM_ASSERT_NEXT_RST(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("ldpm check failed");

`endif

// File: hw/rtl/ldpm_pkg.sv
// Shared types, constants and arithmetic helpers of the lens distortion point map
package ldpm_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int OUT_BITS       = 21;
  localparam int DIV_BITS       = 58;
  localparam int DIV_REM_BITS   = 33;
  localparam int MUL_LAT        = 7;

  typedef logic signed [63:0] word_t;

  localparam word_t SMAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam word_t SMIN    = -64'sh7FFF_FFFF_FFFF_FFFF;
  localparam word_t ONE_Q24 = 64'sd16777216;

  localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMIN65 = -65'sh0_7FFF_FFFF_FFFF_FFFF;

  localparam logic [47:0] OUT_POS_LIM = 48'd1048575;
  localparam logic [47:0] OUT_NEG_LIM = 48'd1048576;
  localparam logic signed [OUT_BITS-1:0] OUT_MAX = 21'sh0FFFFF;
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = 21'sh100000;

  typedef enum logic [2:0] {
    REG_FOCAL  = 3'd0,
    REG_CENTER = 3'd1,
    REG_SKEW   = 3'd2,
    REG_K1     = 3'd3,
    REG_K2     = 3'd4,
    REG_K3     = 3'd5,
    REG_TANG   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic  f;
    word_t v;
  } sword_t;

  typedef struct packed {
    logic [DIV_REM_BITS-1:0] rem;
    logic [DIV_BITS-1:0]     nq;
  } divst_t;

  typedef struct packed {
    logic                        f;
    logic signed [OUT_BITS-1:0]  v;
  } outw_t;

  function automatic sword_t clamp65(input logic signed [64:0] s);
    sword_t r;
    if (s > SMAX65) begin
      r.f = 1'b1;
      r.v = SMAX;
    end else if (s < SMIN65) begin
      r.f = 1'b1;
      r.v = SMIN;
    end else begin
      r.f = 1'b0;
      r.v = s[63:0];
    end
    return r;
  endfunction

  function automatic sword_t sat_add(input word_t a, input word_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    return clamp65(s);
  endfunction

  function automatic sword_t sat_sub(input word_t a, input word_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    return clamp65(s);
  endfunction

  function automatic divst_t div_step(input divst_t s, input logic [DIV_REM_BITS-1:0] dv);
    logic [DIV_REM_BITS:0] t;
    divst_t r;
    t = {s.rem, s.nq[DIV_BITS-1]};
    r.nq = {s.nq[DIV_BITS-2:0], 1'b0};
    if (t >= {1'b0, dv}) begin
      r.rem = DIV_REM_BITS'(t - {1'b0, dv});
      r.nq[0] = 1'b1;
    end else begin
      r.rem = t[DIV_REM_BITS-1:0];
    end
    return r;
  endfunction

  function automatic outw_t round_out(input logic [62:0] m, input logic neg);
    logic [63:0] s;
    logic [47:0] u;
    outw_t r;
    s = {1'b0, m} + 64'd32768;
    u = s[63:16];
    if (!neg) begin
      if (u > OUT_POS_LIM) begin
        r.f = 1'b1;
        r.v = OUT_MAX;
      end else begin
        r.f = 1'b0;
        r.v = u[OUT_BITS-1:0];
      end
    end else begin
      if (u > OUT_NEG_LIM) begin
        r.f = 1'b1;
        r.v = OUT_MIN;
      end else begin
        r.f = 1'b0;
        r.v = -u[OUT_BITS-1:0];
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ldpm_mulsh.sv
// Pipelined signed 64x64 multiply with rounded right shift and saturation
module ldpm_mulsh #(
  parameter int SHIFT = 24
) (
  input  logic            clk,
  input  logic            en,
  input  ldpm_pkg::word_t a,
  input  ldpm_pkg::word_t b,
  output ldpm_pkg::word_t p,
  output logic            ovf
);

  localparam logic [63:0] HALF = 64'd1 << (SHIFT - 1);

  logic [63:0] s1_ua, s1_ub;
  logic        s1_neg;
  logic [63:0] s2_p00, s2_p01, s2_p10, s2_p11;
  logic        s2_neg;
  logic [33:0] s3_mid;
  logic [63:0] s3_hi;
  logic [31:0] s3_lo0;
  logic        s3_neg;
  logic [63:0] s4_lo, s4_hi;
  logic        s4_neg;
  logic [63:0] s5_lo, s5_hi;
  logic        s5_c;
  logic        s5_neg;
  logic [62:0] s6_r;
  logic        s6_ovf;
  logic        s6_neg;

  logic [63:0]  hi2;
  logic [127:0] shifted;
  logic [64:0]  lo_sum;

  always_comb begin
    lo_sum  = {1'b0, s4_lo} + {1'b0, HALF};
    hi2     = s5_hi + 64'(s5_c);
    shifted = {hi2, s5_lo} >> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ua  <= a[63] ? 64'(-a) : 64'(a);
      s1_ub  <= b[63] ? 64'(-b) : 64'(b);
      s1_neg <= a[63] ^ b[63];

      s2_p00 <= s1_ua[31:0]  * s1_ub[31:0];
      s2_p01 <= s1_ua[31:0]  * s1_ub[63:32];
      s2_p10 <= s1_ua[63:32] * s1_ub[31:0];
      s2_p11 <= s1_ua[63:32] * s1_ub[63:32];
      s2_neg <= s1_neg;

      s3_mid <= {2'b0, s2_p00[63:32]} + {2'b0, s2_p01[31:0]} + {2'b0, s2_p10[31:0]};
      s3_hi  <= s2_p11 + {32'b0, s2_p01[63:32]} + {32'b0, s2_p10[63:32]};
      s3_lo0 <= s2_p00[31:0];
      s3_neg <= s2_neg;

      s4_lo  <= {s3_mid[31:0], s3_lo0};
      s4_hi  <= s3_hi + {62'b0, s3_mid[33:32]};
      s4_neg <= s3_neg;

      s5_lo  <= lo_sum[63:0];
      s5_c   <= lo_sum[64];
      s5_hi  <= s4_hi;
      s5_neg <= s4_neg;

      s6_r   <= shifted[62:0];
      s6_ovf <= ((hi2 >> SHIFT) != 64'd0) || shifted[63];
      s6_neg <= s5_neg;

      if (s6_ovf) begin
        p <= s6_neg ? ldpm_pkg::SMIN : ldpm_pkg::SMAX;
      end else begin
        p <= s6_neg ? -ldpm_pkg::word_t'({1'b0, s6_r}) : ldpm_pkg::word_t'({1'b0, s6_r});
      end
      ovf <= s6_ovf;
    end
  end

endmodule

// File: hw/rtl/lens_distortion_point_map.sv
// Lens distortion point map: five-coefficient camera model, one coordinate per cycle
//
//   channel | signals                                   | role
//   pixel   | pixel_valid pixel_ready pixel_x pixel_y   | source coordinate in
//   dist    | dist_valid dist_ready dist_x dist_y clipped | distorted coordinate out
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write
//
// One coordinate per cycle when not stalled; 3 entry stages, a 58-step divider and its
// sign stage, 8 phases of 7-stage multiply plus one add stage, and 2 output rounding stages.
// Reset clears the valid line and the configuration registers; cfg_ready stays high.
// A stalled result freezes the whole pipeline, nothing is lost or repeated.
module lens_distortion_point_map #(
  parameter int COORD_BITS = ldpm_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pixel_valid,
  output logic                     pixel_ready,
  input  logic [COORD_BITS-1:0]    pixel_x,
  input  logic [COORD_BITS-1:0]    pixel_y,
  output logic                     dist_valid,
  input  logic                     dist_ready,
  output logic signed [20:0]       dist_x,
  output logic signed [20:0]       dist_y,
  output logic                     clipped,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [63:0]              cfg_data
);

  localparam int DB  = ldpm_pkg::DIV_BITS;
  localparam int ML  = ldpm_pkg::MUL_LAT;
  localparam int LAT = 3 + DB + 1 + 8 * (ML + 1) + 2;

  typedef struct packed {
    logic            f;
    ldpm_pkg::word_t nx;
    ldpm_pkg::word_t ny;
    ldpm_pkg::word_t r2;
    ldpm_pkg::word_t r4;
    ldpm_pkg::word_t r6;
    ldpm_pkg::word_t a1;
    ldpm_pkg::word_t t2;
    ldpm_pkg::word_t t3;
    ldpm_pkg::word_t a2;
    ldpm_pkg::word_t a3;
    ldpm_pkg::word_t c;
    ldpm_pkg::word_t tx;
    ldpm_pkg::word_t ty;
    ldpm_pkg::word_t xd;
    ldpm_pkg::word_t yd;
    ldpm_pkg::word_t ox;
    ldpm_pkg::word_t oy;
  } live_t;

  logic [63:0] focal_pair, center_pair, tangential_pair;
  logic [31:0] skew, radial_k1, radial_k2, radial_k3;

  logic en;
  logic [LAT-1:0] vld;

  logic [31:0] fx, fy, cx, cy;
  ldpm_pkg::word_t sk_w, k1_w, k2_w, k3_w, p1_w, p2_w, fx_w, fy_w, cx_w, cy_w;
  logic [ldpm_pkg::DIV_REM_BITS-1:0] dvx, dvy;

  assign fx   = focal_pair[63:32];
  assign fy   = focal_pair[31:0];
  assign cx   = center_pair[63:32];
  assign cy   = center_pair[31:0];
  assign sk_w = {{32{skew[31]}}, skew};
  assign k1_w = {{32{radial_k1[31]}}, radial_k1};
  assign k2_w = {{32{radial_k2[31]}}, radial_k2};
  assign k3_w = {{32{radial_k3[31]}}, radial_k3};
  assign p1_w = {{32{tangential_pair[63]}}, tangential_pair[63:32]};
  assign p2_w = {{32{tangential_pair[31]}}, tangential_pair[31:0]};
  assign fx_w = {32'b0, fx};
  assign fy_w = {32'b0, fy};
  assign cx_w = {24'b0, cx, 8'b0};
  assign cy_w = {24'b0, cy, 8'b0};
  assign dvx  = {fx, 1'b0};
  assign dvy  = {fy, 1'b0};

  assign en          = !vld[LAT-1] || dist_ready;
  assign pixel_ready = en;
  assign dist_valid  = vld[LAT-1];
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_pair      <= '0;
      center_pair     <= '0;
      skew            <= '0;
      radial_k1       <= '0;
      radial_k2       <= '0;
      radial_k3       <= '0;
      tangential_pair <= '0;
    end else if (cfg_valid) begin
      unique case (ldpm_pkg::reg_idx_t'(cfg_index))
        ldpm_pkg::REG_FOCAL:  focal_pair      <= cfg_data;
        ldpm_pkg::REG_CENTER: center_pair     <= cfg_data;
        ldpm_pkg::REG_SKEW:   skew            <= cfg_data[31:0];
        ldpm_pkg::REG_K1:     radial_k1       <= cfg_data[31:0];
        ldpm_pkg::REG_K2:     radial_k2       <= cfg_data[31:0];
        ldpm_pkg::REG_K3:     radial_k3       <= cfg_data[31:0];
        ldpm_pkg::REG_TANG:   tangential_pair <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pixel_valid};
    end
  end

  // entry stages and divider
  logic signed [33:0] nx_num, ny_num;
  logic [31:0] ux_mag, uy_mag;
  logic        ux_neg, uy_neg;
  ldpm_pkg::divst_t dx [DB+1];
  ldpm_pkg::divst_t dy [DB+1];
  logic [DB:0] dx_neg, dy_neg;

  live_t ph [9];
  live_t dl [1:8][ML];
  live_t ph0_next;

  always_comb begin
    ph0_next    = '0;
    ph0_next.nx = (fx == 32'd0) ? '0 :
                  dx_neg[DB] ? -ldpm_pkg::word_t'(dx[DB].nq) : ldpm_pkg::word_t'(dx[DB].nq);
    ph0_next.ny = (fy == 32'd0) ? '0 :
                  dy_neg[DB] ? -ldpm_pkg::word_t'(dy[DB].nq) : ldpm_pkg::word_t'(dy[DB].nq);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_num <= (34'(pixel_x) << 16) - {2'b0, cx};
      ny_num <= (34'(pixel_y) << 16) - {2'b0, cy};
      ux_mag <= nx_num[33] ? 32'(-nx_num) : nx_num[31:0];
      uy_mag <= ny_num[33] ? 32'(-ny_num) : ny_num[31:0];
      ux_neg <= nx_num[33];
      uy_neg <= ny_num[33];
      dx[0]  <= '{rem: '0, nq: {1'b0, ux_mag, 25'b0} + DB'(fx)};
      dy[0]  <= '{rem: '0, nq: {1'b0, uy_mag, 25'b0} + DB'(fy)};
      dx_neg[0] <= ux_neg;
      dy_neg[0] <= uy_neg;
      for (int j = 1; j <= DB; j++) begin
        dx[j]     <= ldpm_pkg::div_step(dx[j-1], dvx);
        dy[j]     <= ldpm_pkg::div_step(dy[j-1], dvy);
        dx_neg[j] <= dx_neg[j-1];
        dy_neg[j] <= dy_neg[j-1];
      end
      ph[0] <= ph0_next;
      for (int k = 1; k <= 8; k++) begin
        dl[k][0] <= ph[k-1];
        for (int i = 1; i < ML; i++) begin
          dl[k][i] <= dl[k][i-1];
        end
      end
    end
  end

  // multipliers, grouped by phase
  ldpm_pkg::word_t m1_sky;
  ldpm_pkg::word_t m2_x2, m2_y2, m2_xy;
  ldpm_pkg::word_t m3_r4, m3_k1;
  ldpm_pkg::word_t m4_r6, m4_k2, m4_q1, m4_q2, m4_q3, m4_q4;
  ldpm_pkg::word_t m5_k3;
  ldpm_pkg::word_t m6_xd, m6_yd;
  ldpm_pkg::word_t m7_sk, m7_fy;
  ldpm_pkg::word_t m8_fx;
  logic o1_sky, o2_x2, o2_y2, o2_xy, o3_r4, o3_k1;
  logic o4_r6, o4_k2, o4_q1, o4_q2, o4_q3, o4_q4;
  logic o5_k3, o6_xd, o6_yd, o7_sk, o7_fy, o8_fx;

  ldpm_mulsh #(.SHIFT(28)) u_m1_sky (.clk, .en, .a(sk_w), .b(ph[0].ny), .p(m1_sky), .ovf(o1_sky));
  ldpm_mulsh #(.SHIFT(24)) u_m2_x2 (.clk, .en, .a(ph[1].nx), .b(ph[1].nx), .p(m2_x2), .ovf(o2_x2));
  ldpm_mulsh #(.SHIFT(24)) u_m2_y2 (.clk, .en, .a(ph[1].ny), .b(ph[1].ny), .p(m2_y2), .ovf(o2_y2));
  ldpm_mulsh #(.SHIFT(24)) u_m2_xy (.clk, .en, .a(ph[1].nx), .b(ph[1].ny), .p(m2_xy), .ovf(o2_xy));
  ldpm_mulsh #(.SHIFT(24)) u_m3_r4 (.clk, .en, .a(ph[2].r2), .b(ph[2].r2), .p(m3_r4), .ovf(o3_r4));
  ldpm_mulsh #(.SHIFT(24)) u_m3_k1 (.clk, .en, .a(k1_w), .b(ph[2].r2), .p(m3_k1), .ovf(o3_k1));
  ldpm_mulsh #(.SHIFT(24)) u_m4_r6 (.clk, .en, .a(ph[3].r4), .b(ph[3].r2), .p(m4_r6), .ovf(o4_r6));
  ldpm_mulsh #(.SHIFT(24)) u_m4_k2 (.clk, .en, .a(k2_w), .b(ph[3].r4), .p(m4_k2), .ovf(o4_k2));
  ldpm_mulsh #(.SHIFT(24)) u_m4_q1 (.clk, .en, .a(p1_w), .b(ph[3].a1), .p(m4_q1), .ovf(o4_q1));
  ldpm_mulsh #(.SHIFT(24)) u_m4_q2 (.clk, .en, .a(p2_w), .b(ph[3].a2), .p(m4_q2), .ovf(o4_q2));
  ldpm_mulsh #(.SHIFT(24)) u_m4_q3 (.clk, .en, .a(p1_w), .b(ph[3].a3), .p(m4_q3), .ovf(o4_q3));
  ldpm_mulsh #(.SHIFT(24)) u_m4_q4 (.clk, .en, .a(p2_w), .b(ph[3].a1), .p(m4_q4), .ovf(o4_q4));
  ldpm_mulsh #(.SHIFT(24)) u_m5_k3 (.clk, .en, .a(k3_w), .b(ph[4].r6), .p(m5_k3), .ovf(o5_k3));
  ldpm_mulsh #(.SHIFT(24)) u_m6_xd (.clk, .en, .a(ph[5].nx), .b(ph[5].c), .p(m6_xd), .ovf(o6_xd));
  ldpm_mulsh #(.SHIFT(24)) u_m6_yd (.clk, .en, .a(ph[5].ny), .b(ph[5].c), .p(m6_yd), .ovf(o6_yd));
  ldpm_mulsh #(.SHIFT(28)) u_m7_sk (.clk, .en, .a(sk_w), .b(ph[6].yd), .p(m7_sk), .ovf(o7_sk));
  ldpm_mulsh #(.SHIFT(16)) u_m7_fy (.clk, .en, .a(fy_w), .b(ph[6].yd), .p(m7_fy), .ovf(o7_fy));
  ldpm_mulsh #(.SHIFT(16)) u_m8_fx (.clk, .en, .a(fx_w), .b(ph[7].xd), .p(m8_fx), .ovf(o8_fx));

  // add stage closing each phase
  live_t nxt1, nxt2, nxt3, nxt4, nxt5, nxt6, nxt7, nxt8;

  always_comb begin
    ldpm_pkg::sword_t s;
    nxt1 = dl[1][ML-1];
    s = ldpm_pkg::sat_sub(nxt1.nx, m1_sky);
    nxt1.nx = s.v;
    nxt1.f  = nxt1.f | s.f | o1_sky;
  end

  always_comb begin
    ldpm_pkg::sword_t sr, sa, sx, sy;
    nxt2 = dl[2][ML-1];
    sr = ldpm_pkg::sat_add(m2_x2, m2_y2);
    sa = ldpm_pkg::sat_add(m2_xy, m2_xy);
    sx = ldpm_pkg::sat_add(m2_x2, m2_x2);
    sy = ldpm_pkg::sat_add(m2_y2, m2_y2);
    nxt2.r2 = sr.v;
    nxt2.a1 = sa.v;
    nxt2.t2 = sx.v;
    nxt2.t3 = sy.v;
    nxt2.f  = nxt2.f | sr.f | sa.f | sx.f | sy.f | o2_x2 | o2_y2 | o2_xy;
  end

  always_comb begin
    ldpm_pkg::sword_t sc, s2, s3;
    nxt3 = dl[3][ML-1];
    sc = ldpm_pkg::sat_add(ldpm_pkg::ONE_Q24, m3_k1);
    s2 = ldpm_pkg::sat_add(nxt3.r2, nxt3.t2);
    s3 = ldpm_pkg::sat_add(nxt3.r2, nxt3.t3);
    nxt3.r4 = m3_r4;
    nxt3.c  = sc.v;
    nxt3.a2 = s2.v;
    nxt3.a3 = s3.v;
    nxt3.f  = nxt3.f | sc.f | s2.f | s3.f | o3_r4 | o3_k1;
  end

  always_comb begin
    ldpm_pkg::sword_t sc, sx, sy;
    nxt4 = dl[4][ML-1];
    sc = ldpm_pkg::sat_add(nxt4.c, m4_k2);
    sx = ldpm_pkg::sat_add(m4_q1, m4_q2);
    sy = ldpm_pkg::sat_add(m4_q3, m4_q4);
    nxt4.r6 = m4_r6;
    nxt4.c  = sc.v;
    nxt4.tx = sx.v;
    nxt4.ty = sy.v;
    nxt4.f  = nxt4.f | sc.f | sx.f | sy.f | o4_r6 | o4_k2 | o4_q1 | o4_q2 | o4_q3 | o4_q4;
  end

  always_comb begin
    ldpm_pkg::sword_t sc;
    nxt5 = dl[5][ML-1];
    sc = ldpm_pkg::sat_add(nxt5.c, m5_k3);
    nxt5.c = sc.v;
    nxt5.f = nxt5.f | sc.f | o5_k3;
  end

  always_comb begin
    ldpm_pkg::sword_t sx, sy;
    nxt6 = dl[6][ML-1];
    sx = ldpm_pkg::sat_add(m6_xd, nxt6.tx);
    sy = ldpm_pkg::sat_add(m6_yd, nxt6.ty);
    nxt6.xd = sx.v;
    nxt6.yd = sy.v;
    nxt6.f  = nxt6.f | sx.f | sy.f | o6_xd | o6_yd;
  end

  always_comb begin
    ldpm_pkg::sword_t sx, sy;
    nxt7 = dl[7][ML-1];
    sx = ldpm_pkg::sat_add(nxt7.xd, m7_sk);
    sy = ldpm_pkg::sat_add(m7_fy, cy_w);
    nxt7.xd = sx.v;
    nxt7.oy = sy.v;
    nxt7.f  = nxt7.f | sx.f | sy.f | o7_sk | o7_fy;
  end

  always_comb begin
    ldpm_pkg::sword_t sx;
    nxt8 = dl[8][ML-1];
    sx = ldpm_pkg::sat_add(m8_fx, cx_w);
    nxt8.ox = sx.v;
    nxt8.f  = nxt8.f | sx.f | o8_fx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph[1] <= nxt1;
      ph[2] <= nxt2;
      ph[3] <= nxt3;
      ph[4] <= nxt4;
      ph[5] <= nxt5;
      ph[6] <= nxt6;
      ph[7] <= nxt7;
      ph[8] <= nxt8;
    end
  end

  // output rounding
  logic [62:0] fm_x, fm_y;
  logic        fn_x, fn_y, ff;
  ldpm_pkg::outw_t rx, ry;

  assign rx = ldpm_pkg::round_out(fm_x, fn_x);
  assign ry = ldpm_pkg::round_out(fm_y, fn_y);

  always_ff @(posedge clk) begin
    if (en) begin
      fm_x    <= ph[8].ox[63] ? 63'(-ph[8].ox) : ph[8].ox[62:0];
      fm_y    <= ph[8].oy[63] ? 63'(-ph[8].oy) : ph[8].oy[62:0];
      fn_x    <= ph[8].ox[63];
      fn_y    <= ph[8].oy[63];
      ff      <= ph[8].f;
      dist_x  <= rx.v;
      dist_y  <= ry.v;
      clipped <= ff | rx.f | ry.f;
    end
  end

endmodule

// File: hw/rtl/ldpm_checker.sv
// Port-level assertion checker for the lens distortion point map, with its bind
`include "lens_distortion_point_map_defines.svh"

module ldpm_checker (
  input logic              clk,
  input logic              rst,
  input logic              pixel_ready,
  input logic              dist_valid,
  input logic              dist_ready,
  input logic signed [20:0] dist_x,
  input logic signed [20:0] dist_y,
  input logic              clipped,
  input logic              cfg_ready
);

  `LDPM_ASSERT_NEXT_RST(a_rst_empty, rst, !dist_valid)
  `LDPM_ASSERT_NOW(a_ready_tracks_out, pixel_ready == (!dist_valid || dist_ready) && cfg_ready)
  `LDPM_ASSERT_NEXT(a_out_hold, dist_valid && !dist_ready, dist_valid)
  `LDPM_ASSERT_NEXT(a_out_stable, dist_valid && !dist_ready, $stable(dist_x) && $stable(dist_y) && $stable(clipped))

endmodule

bind lens_distortion_point_map ldpm_checker u_ldpm_checker (.*);

// File: test/tb_lens_distortion_point_map.sv
// Self-checking testbench for the lens distortion point map with a built-in fixed-point predictor
module tb_lens_distortion_point_map;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 12;
  localparam longint QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int LIMIT = 1500000;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int HOLD_ITEMS = 300;
  localparam int PHASES = 14;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } pixel_t;

  typedef struct {
    logic signed [20:0] dx;
    logic signed [20:0] dy;
    logic               clip;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  logic [CW-1:0] pixel_x = '0;
  logic [CW-1:0] pixel_y = '0;
  logic dist_valid;
  logic dist_ready = 1'b0;
  logic signed [20:0] dist_x;
  logic signed [20:0] dist_y;
  logic clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  pixel_t pixel_q[$];
  point_t dist_expect[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int tx_gap = 0;
  int rx_hold = 0;

  bit [31:0] fx, fy, cx, cy;
  int sk, k1, k2, k3, p1, p2;
  bit ovf;

  lens_distortion_point_map #(.COORD_BITS(CW)) dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .dist_valid(dist_valid), .dist_ready(dist_ready),
    .dist_x(dist_x), .dist_y(dist_y), .clipped(clipped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic bit [63:0] mag(input longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint sum_sat(input longint a, input longint b);
    if (b > 0 && a > QMAX - b) begin
      ovf = 1'b1;
      return QMAX;
    end
    if (b < 0 && a < -QMAX - b) begin
      ovf = 1'b1;
      return -QMAX;
    end
    if (a == -QMAX - 1) begin
      ovf = 1'b1;
      a = -QMAX;
    end
    return a + b;
  endfunction

  function automatic longint mul_round(input longint a, input longint b, input int sh);
    bit [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = {64'b0, mag(a)} * {64'b0, mag(b)};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    if (p > 128'(QMAX)) begin
      ovf = 1'b1;
      return neg ? -QMAX : QMAX;
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint div_round(input longint n, input bit [31:0] d32);
    bit [63:0] d, q;
    d = {32'b0, d32};
    if (d == 0) return 0;
    q = ((mag(n) << 25) + d) / (d << 1);
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [20:0] to_q8(input longint r);
    bit [63:0] u;
    longint v;
    u = (mag(r) + 64'd32768) >> 16;
    v = r < 0 ? -longint'(u) : longint'(u);
    if (v > 1048575) begin
      v = 1048575;
      ovf = 1'b1;
    end
    if (v < -1048576) begin
      v = -1048576;
      ovf = 1'b1;
    end
    return v[20:0];
  endfunction

  function automatic point_t distort_point(input pixel_t px);
    longint nx, ny, x2, y2, r2, r4, r6, c, xd, yd, xy, a1, a2, a3, ox, oy;
    longint cxl, cyl;
    point_t e;
    ovf = 1'b0;
    cxl = longint'(cx);
    cyl = longint'(cy);
    ny = div_round(longint'(px.y) * 65536 - cyl, fy);
    nx = sum_sat(div_round(longint'(px.x) * 65536 - cxl, fx), -mul_round(sk, ny, 28));
    x2 = mul_round(nx, nx, 24);
    y2 = mul_round(ny, ny, 24);
    r2 = sum_sat(x2, y2);
    r4 = mul_round(r2, r2, 24);
    r6 = mul_round(r4, r2, 24);
    c = 64'sd16777216;
    c = sum_sat(c, mul_round(k1, r2, 24));
    c = sum_sat(c, mul_round(k2, r4, 24));
    c = sum_sat(c, mul_round(k3, r6, 24));
    xd = mul_round(nx, c, 24);
    yd = mul_round(ny, c, 24);
    xy = mul_round(nx, ny, 24);
    a1 = sum_sat(xy, xy);
    a2 = sum_sat(r2, sum_sat(x2, x2));
    a3 = sum_sat(r2, sum_sat(y2, y2));
    xd = sum_sat(xd, sum_sat(mul_round(p1, a1, 24), mul_round(p2, a2, 24)));
    yd = sum_sat(yd, sum_sat(mul_round(p1, a3, 24), mul_round(p2, a1, 24)));
    ox = sum_sat(mul_round(longint'(fx), sum_sat(xd, mul_round(sk, yd, 28)), 16), cxl * 256);
    oy = sum_sat(mul_round(longint'(fy), yd, 16), cyl * 256);
    e.dx = to_q8(ox);
    e.dy = to_q8(oy);
    e.clip = ovf;
    return e;
  endfunction

  function automatic void load_reg(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      ldpm_pkg::REG_FOCAL: begin
        fx = val[63:32];
        fy = val[31:0];
      end
      ldpm_pkg::REG_CENTER: begin
        cx = val[63:32];
        cy = val[31:0];
      end
      ldpm_pkg::REG_SKEW: sk = val[31:0];
      ldpm_pkg::REG_K1: k1 = val[31:0];
      ldpm_pkg::REG_K2: k2 = val[31:0];
      ldpm_pkg::REG_K3: k3 = val[31:0];
      ldpm_pkg::REG_TANG: begin
        p1 = val[63:32];
        p2 = val[31:0];
      end
      default: ;
    endcase
  endfunction

  function automatic void add_pixel(input logic [CW-1:0] x, input logic [CW-1:0] y);
    pixel_t p;
    p.x = x;
    p.y = y;
    pixel_q.insert(pixel_q.size(), p);
  endfunction

  function automatic void add_expect(input pixel_t p);
    point_t e;
    e = distort_point(p);
    dist_expect.insert(dist_expect.size(), e);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready)
        add_expect('{pixel_x, pixel_y});
      if (!(pixel_valid && !pixel_ready)) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          pixel_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          pixel_t p;
          p = pixel_q.pop_front();
          pixel_x <= p.x;
          pixel_y <= p.y;
          pixel_valid <= 1'b1;
          tx_gap <= pick_gap();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      dist_ready <= 1'b0;
    end else begin
      if (dist_valid && dist_ready) begin
        if (dist_expect.size() == 0) begin
          report("unexpected beat", dist_x, 0);
        end else begin
          point_t e;
          e = dist_expect.pop_front();
          if (dist_x !== e.dx) report("dist_x", dist_x, e.dx);
          if (dist_y !== e.dy) report("dist_y", dist_y, e.dy);
          if (clipped !== e.clip) report("clipped", clipped, e.clip);
        end
      end
      if (hold_req && rx_hold == 0) begin
        rx_hold <= 400;
        hold_req <= 1'b0;
        dist_ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        dist_ready <= 1'b0;
      end else if (calm) begin
        dist_ready <= 1'b1;
      end else begin
        dist_ready <= ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 99) < 4) rx_hold <= $urandom_range(8, 40);
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    load_reg(idx, val);
  endtask

  task automatic program_regs(input logic [63:0] foc, input logic [63:0] ctr,
                              input logic [31:0] s, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] c,
                              input logic [63:0] tg);
    cfg_write(ldpm_pkg::REG_FOCAL, foc);
    cfg_write(ldpm_pkg::REG_CENTER, ctr);
    cfg_write(ldpm_pkg::REG_SKEW, {32'($urandom), s});
    cfg_write(ldpm_pkg::REG_K1, {32'($urandom), a});
    cfg_write(ldpm_pkg::REG_K2, {32'($urandom), b});
    cfg_write(ldpm_pkg::REG_K3, {32'($urandom), c});
    cfg_write(ldpm_pkg::REG_TANG, tg);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    int quiet;
    quiet = 0;
    while (quiet < 2) begin
      @(posedge clk);
      if (pixel_q.size() > 0 || pixel_valid || dist_expect.size() > 0)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  function automatic logic [31:0] sym(input int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  task automatic program_lens();
    program_regs({16'($urandom_range(300, 3000)), 16'($urandom),
                  16'($urandom_range(300, 3000)), 16'($urandom)},
                 {16'($urandom_range(0, 4095)), 16'($urandom),
                  16'($urandom_range(0, 4095)), 16'($urandom)},
                 sym(1 << 21), sym(1 << 23), sym(1 << 22), sym(1 << 20),
                 {sym(1 << 17), sym(1 << 17)});
  endtask

  initial begin
    fx = 0; fy = 0; cx = 0; cy = 0;
    sk = 0; k1 = 0; k2 = 0; k3 = 0; p1 = 0; p2 = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_pixel(12'd0, 12'd0);
    add_pixel(12'hFFF, 12'hFFF);
    add_pixel(12'd0, 12'hFFF);
    add_pixel(12'hFFF, 12'd0);
    drain();

    cfg_write(REG_UNUSED, 64'hDEAD_BEEF_1234_5678);
    cfg_valid <= 1'b0;
    program_regs({32'd1000 << 16, 32'd1000 << 16}, {32'd2048 << 16, 32'd1536 << 16},
                 32'd0, 32'hFF80_0000, 32'h0020_0000, 32'hFFF0_0000,
                 {32'h0001_0000, 32'hFFFF_8000});
    add_pixel(12'd0, 12'd0);
    add_pixel(12'hFFF, 12'hFFF);
    add_pixel(12'd2048, 12'd1536);
    add_pixel(12'hAAA, 12'h555);
    add_pixel(12'h555, 12'hAAA);
    add_pixel(12'd0, 12'hFFF);
    drain();

    program_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 64'h8000_0000_7FFF_FFFF);
    add_pixel(12'd0, 12'd0);
    add_pixel(12'hFFF, 12'hFFF);
    add_pixel(12'hFFF, 12'd0);
    drain();

    program_regs({32'd1, 32'd0}, 64'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 64'h7FFF_FFFF_8000_0000);
    add_pixel(12'd0, 12'd0);
    add_pixel(12'hFFF, 12'hFFF);
    add_pixel(12'd1, 12'd1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      int n_items;
      case (ph % 4)
        0: program_lens();
        1: program_regs({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom,
                        $urandom, $urandom, {$urandom, $urandom});
        2: program_lens();
        default: begin
          program_lens();
          cfg_write(ldpm_pkg::REG_FOCAL, {($urandom_range(0, 1) ? 32'd0 : fx),
                                         ($urandom_range(0, 1) ? fy : 32'd0)});
          cfg_valid <= 1'b0;
        end
      endcase
      calm = (ph % 5 == 4);
      n_items = ITEMS_PER_PHASE;
      if (ph == 2 || ph == 9) begin
        calm = 1'b1;
        hold_req = 1'b1;
        n_items = HOLD_ITEMS;
      end
      for (int i = 0; i < n_items; i++)
        add_pixel(12'($urandom), 12'($urandom));
      drain();
      calm = 1'b0;
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && dist_expect.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
